/* sv/raster_palette_planar_to_rgb_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the planar-to-RGB palette decoder
// Shared helpers so the modules that hold checks state them the same way.
// ----------------------------------------------------------------------------
`ifndef RASTER_PALETTE_PLANAR_TO_RGB_UNIT_MACROS_SVH
`define RASTER_PALETTE_PLANAR_TO_RGB_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RPP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpp: implication check failed");

// Next-cycle implication, disabled during reset.
`define RPP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpp: next-cycle check failed");

`endif

/* sv/rpp_pkg.sv */
// ----------------------------------------------------------------------------
// rpp_pkg
// Types, constants and helper functions of the planar-to-RGB decoder.
// ----------------------------------------------------------------------------
package rpp_pkg;

  localparam int GROUPS_PER_LINE  = 20;
  localparam int GROUP_W          = 5;
  localparam int PIXELS_PER_GROUP = 16;
  localparam int PIX_W            = 4;
  localparam int X_W              = GROUP_W + PIX_W;
  localparam int PAL_DEPTH        = 32;
  localparam int PAL_IDX_W        = 5;
  localparam int PAL_W            = 12;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = 1;
  localparam int QCNT_W           = 2;

  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_GROUP   = 1'b1;

  // Pixel position at which color c switches from entry c to entry c+16.
  // For odd c this is 10c + 70, for even c 10c + 76, plus 12 when c > 7.
  localparam logic [X_W-1:0] SWITCH_X [PIXELS_PER_GROUP] = '{
    9'd76,  9'd80,  9'd96,  9'd100, 9'd116, 9'd120, 9'd136, 9'd140,
    9'd168, 9'd172, 9'd188, 9'd192, 9'd208, 9'd212, 9'd228, 9'd232
  };

  typedef struct packed {
    logic                 kind;
    logic                 palette_select;
    logic [PAL_IDX_W-1:0] palette_index;
    logic [PAL_W-1:0]     color;
    logic [GROUP_W-1:0]   group_index;
    logic [15:0]          plane_a;
    logic [15:0]          plane_b;
    logic [15:0]          plane_c;
    logic [15:0]          plane_d;
  } item_t;

  // 4-bit STe channel to 8 bits: rotate the nibble left by one, then repeat.
  function automatic logic [7:0] expand_nibble(input logic [3:0] n);
    logic [3:0] m;
    m = {n[2:0], n[3]};
    return {m, m};
  endfunction

  // Floor average of one channel of two palette words.
  function automatic logic [7:0] blend(input logic [3:0] n0, input logic [3:0] n1);
    logic [8:0] sum;
    sum = {1'b0, expand_nibble(n0)} + {1'b0, expand_nibble(n1)};
    return sum[8:1];
  endfunction

endpackage

/* sv/rpp_front.sv */
// ----------------------------------------------------------------------------
// rpp_front
// Input stage: registers each transfer, classifies it and forwards it.
// ----------------------------------------------------------------------------
module rpp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic                kind,
  input  logic                palette_select,
  input  logic [4:0]          palette_index,
  input  logic [15:0]         color_word,
  input  logic [4:0]          group_index,
  input  logic [15:0]         plane_a,
  input  logic [15:0]         plane_b,
  input  logic [15:0]         plane_c,
  input  logic [15:0]         plane_d,
  output logic                push,
  output rpp_pkg::item_t      push_item,
  input  logic                queue_ready
);
  import rpp_pkg::*;

  logic  held_valid;
  item_t held;
  item_t classified;

  always_comb begin
    classified                = '0;
    classified.kind           = kind;
    classified.palette_select = palette_select;
    classified.palette_index  = palette_index;
    classified.color          = color_word[PAL_W-1:0];
    // Groups past the end of the line clamp to the last group.
    if (group_index > GROUP_W'(GROUPS_PER_LINE - 1)) begin
      classified.group_index = GROUP_W'(GROUPS_PER_LINE - 1);
    end else begin
      classified.group_index = group_index;
    end
    classified.plane_a = plane_a;
    classified.plane_b = plane_b;
    classified.plane_c = plane_c;
    classified.plane_d = plane_d;
  end

  assign item_ready = !held_valid || queue_ready;
  assign push       = held_valid;
  assign push_item  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      held <= classified;
    end
  end

endmodule

/* sv/rpp_queue.sv */
// ----------------------------------------------------------------------------
// rpp_queue
// Short in-order queue between the input stage and the pixel engine.
// ----------------------------------------------------------------------------
`include "raster_palette_planar_to_rgb_unit_macros.svh"

module rpp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rpp_pkg::item_t  push_item,
  output logic            queue_ready,
  output logic            head_valid,
  output rpp_pkg::item_t  head_item,
  input  logic            pop
);
  import rpp_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign queue_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign head_valid  = count != '0;
  assign head_item   = slots[rd_ptr];
  assign do_push     = push && queue_ready;
  assign do_pop      = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `RPP_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= QCNT_W'(QUEUE_DEPTH))
  `RPP_ASSERT_NXT(a_push_counts, clk, rst, do_push && !do_pop, count != '0)
  `RPP_ASSERT_NXT(a_pop_frees, clk, rst, do_pop && !do_push, queue_ready)

endmodule

/* sv/rpp_back.sv */
// ----------------------------------------------------------------------------
// rpp_back
// Pixel engine: applies palette writes, expands plane groups to 16 pixels.
// ----------------------------------------------------------------------------
`include "raster_palette_planar_to_rgb_unit_macros.svh"

module rpp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  rpp_pkg::item_t  head_item,
  output logic            pop,
  output logic            pixel_valid,
  input  logic            pixel_ready,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue,
  output logic            last_pixel
);
  import rpp_pkg::*;

  logic [PAL_W-1:0]     pal_first  [PAL_DEPTH];
  logic [PAL_W-1:0]     pal_second [PAL_DEPTH];

  logic                 cur_valid;
  logic [GROUP_W-1:0]   cur_group;
  logic [15:0]          cur_a;
  logic [15:0]          cur_b;
  logic [15:0]          cur_c;
  logic [15:0]          cur_d;
  logic [PIX_W-1:0]     px;

  logic                 s1_valid;
  logic                 s1_last;
  logic [PAL_W-1:0]     rd_first;
  logic [PAL_W-1:0]     rd_second;

  logic                 adv;
  logic                 issue;
  logic                 cur_free;
  logic [PIX_W-1:0]     bit_sel;
  logic [3:0]           color;
  logic [X_W-1:0]       xpos;
  logic [PAL_IDX_W-1:0] entry;
  logic                 last_issue;

  assign adv        = !pixel_valid || pixel_ready;
  assign issue      = cur_valid && adv;
  assign last_issue = issue && (px == PIX_W'(PIXELS_PER_GROUP - 1));
  assign cur_free   = !cur_valid || last_issue;
  assign pop        = head_valid && cur_free;

  // Bit 15 of each plane is the leftmost pixel.
  assign bit_sel = ~px;
  assign color   = {cur_d[bit_sel], cur_c[bit_sel], cur_b[bit_sel], cur_a[bit_sel]};
  assign xpos    = {cur_group, px};
  assign entry   = {xpos >= SWITCH_X[color], color};

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      px        <= '0;
    end else begin
      if (issue) begin
        px <= px + 1'b1;
      end
      if (pop) begin
        cur_valid <= head_item.kind == KIND_GROUP;
      end else if (last_issue) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.kind == KIND_GROUP) begin
      cur_group <= head_item.group_index;
      cur_a     <= head_item.plane_a;
      cur_b     <= head_item.plane_b;
      cur_c     <= head_item.plane_c;
      cur_d     <= head_item.plane_d;
    end
  end

  // Palette memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (pop && head_item.kind == KIND_PALETTE && !head_item.palette_select) begin
      pal_first[head_item.palette_index] <= head_item.color;
    end
    if (issue) begin
      rd_first <= pal_first[entry];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.kind == KIND_PALETTE && head_item.palette_select) begin
      pal_second[head_item.palette_index] <= head_item.color;
    end
    if (issue) begin
      rd_second <= pal_second[entry];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      pixel_valid <= 1'b0;
    end else if (adv) begin
      s1_valid    <= cur_valid;
      pixel_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last    <= px == PIX_W'(PIXELS_PER_GROUP - 1);
      red        <= blend(rd_first[11:8], rd_second[11:8]);
      green      <= blend(rd_first[7:4], rd_second[7:4]);
      blue       <= blend(rd_first[3:0], rd_second[3:0]);
      last_pixel <= s1_last;
    end
  end

  `RPP_ASSERT_IMP(a_idle_at_pixel_zero, clk, rst, !cur_valid, px == '0)
  `RPP_ASSERT_NXT(a_last_issue_tags, clk, rst, last_issue, s1_valid && s1_last)
  `RPP_ASSERT_NXT(a_last_reaches_out, clk, rst, adv && s1_valid && s1_last,
                  pixel_valid && last_pixel)

endmodule

/* sv/raster_palette_planar_to_rgb_unit.sv */
// ----------------------------------------------------------------------------
// raster_palette_planar_to_rgb_unit
// Decodes 4-bitplane groups of 16 pixels to RGB through two line palettes.
// ----------------------------------------------------------------------------
// The first pixel of a group passes the input register, the queue, the
// group register, the palette read register and the output register.
// Throughput: one pixel per cycle while pixel_ready allows, set by the single
// read port of each palette memory. Reset clears the input stage, the queue,
// the pixel engine and the output register; the palette memories keep their
// contents and are undefined until written.
// ----------------------------------------------------------------------------
module raster_palette_planar_to_rgb_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        kind,
  input  logic        palette_select,
  input  logic [4:0]  palette_index,
  input  logic [15:0] color_word,
  input  logic [4:0]  group_index,
  input  logic [15:0] plane_a,
  input  logic [15:0] plane_b,
  input  logic [15:0] plane_c,
  input  logic [15:0] plane_d,
  output logic        pixel_valid,
  input  logic        pixel_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        last_pixel
);
  import rpp_pkg::*;

  // The front registers every input transfer, clamps the group position and
  // drops the unused top bits of the palette word. Palette writes and plane
  // groups share one in-order queue, so a write lands only after every pixel
  // of earlier groups has read the palettes, and before any later group reads them.
  logic  push;
  item_t push_item;
  logic  queue_ready;
  logic  head_valid;
  item_t head_item;
  logic  pop;

  rpp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .kind           (kind),
    .palette_select (palette_select),
    .palette_index  (palette_index),
    .color_word     (color_word),
    .group_index    (group_index),
    .plane_a        (plane_a),
    .plane_b        (plane_b),
    .plane_c        (plane_c),
    .plane_d        (plane_d),
    .push           (push),
    .push_item      (push_item),
    .queue_ready    (queue_ready)
  );

  // The queue lets the front keep taking transfers while the engine is busy
  // with a group or stalled by the pixel consumer.
  rpp_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_item   (push_item),
    .queue_ready (queue_ready),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop)
  );

  // The engine walks the 16 pixels of a group, picks entry c or c+16 from the
  // pixel position, reads both palettes, and averages the expanded channels
  // into the output register. The pixel walk and its pipeline hold while a pixel waits.
  rpp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last_pixel  (last_pixel)
  );

endmodule

/* bench/tb_raster_palette_planar_to_rgb_unit.sv */
// ----------------------------------------------------------------------------
// Testbench for raster_palette_planar_to_rgb_unit
// Streams palette writes and plane groups into the decoder, predicts the 16
// RGB pixels of every group from a private copy of both line palettes, and
// checks each pixel transfer against the oldest prediction. Both handshakes
// see random gaps, and at two points the sender waits for the pixel stream to
// drain completely.
// ----------------------------------------------------------------------------
module tb_raster_palette_planar_to_rgb_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rpp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int TAIL_CYCLES    = 16;
  localparam int IDLE_PCT       = 8;
  localparam int CALM_FROM      = 1500;  // window of cycles with no idling at all
  localparam int CALM_TO        = 2700;
  localparam int RANDOM_ITEMS   = 230;

  // One pending input transfer. The hold flag makes the sender wait until
  // every predicted pixel has been seen before it offers this item.
  typedef struct {
    bit        hold;
    bit        kind;
    bit        sel;
    bit [4:0]  idx;
    bit [15:0] word;
    bit [4:0]  grp;
    bit [15:0] pa;
    bit [15:0] pb;
    bit [15:0] pc;
    bit [15:0] pd;
  } planar_item_t;

  typedef struct {
    bit [7:0] r;
    bit [7:0] g;
    bit [7:0] b;
    bit       last;
  } rgb_pixel_t;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        item_valid     = 1'b0;
  logic        item_ready;
  logic        kind           = 1'b0;
  logic        palette_select = 1'b0;
  logic [4:0]  palette_index  = '0;
  logic [15:0] color_word     = '0;
  logic [4:0]  group_index    = '0;
  logic [15:0] plane_a        = '0;
  logic [15:0] plane_b        = '0;
  logic [15:0] plane_c        = '0;
  logic [15:0] plane_d        = '0;
  logic        pixel_valid;
  logic        pixel_ready    = 1'b0;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_pixel;

  planar_item_t pending[$];       // items waiting to be offered
  rgb_pixel_t   pixel_expect[$];  // predicted pixels, oldest first

  // Predictor copy of the two line palettes, updated at each write transfer.
  bit [11:0] pal_first  [PAL_DEPTH];
  bit [11:0] pal_second [PAL_DEPTH];

  // Which entries the generator has already scheduled a write for. A group is
  // only queued once every entry it reads has been written in both palettes.
  bit filled_first  [PAL_DEPTH];
  bit filled_second [PAL_DEPTH];
  bit hold_next = 1'b0;

  int item_offers  = 0;
  int item_xfers   = 0;
  int quiet_cycles = 0;
  int cyc          = 0;
  int errors       = 0;
  int total_items;

  raster_palette_planar_to_rgb_unit u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // STe channel: the low three bits move up one place, the top bit drops to
  // bit zero, and the nibble is repeated into both halves of the byte.
  function automatic bit [7:0] widen_nibble(input bit [3:0] n);
    bit [7:0] v;
    v = {4'd0, n[2:0], n[3]};
    return v * 8'h11;
  endfunction

  // Floor average of the widened nibbles of both palettes.
  function automatic bit [7:0] mix_channel(input bit [3:0] n0, input bit [3:0] n1);
    bit [8:0] sum;
    sum = {1'b0, widen_nibble(n0)} + {1'b0, widen_nibble(n1)};
    return sum[8:1];
  endfunction

  // Color of pixel i of a group; pixel 0 is the MSB of every plane.
  function automatic bit [3:0] pixel_color(input bit [15:0] pa, input bit [15:0] pb,
                                           input bit [15:0] pc, input bit [15:0] pd,
                                           input int i);
    int bp;
    bp = 15 - i;
    return {pd[bp], pc[bp], pb[bp], pa[bp]};
  endfunction

  // Odd colors switch earlier than even ones, and the upper eight colors are
  // pushed twelve pixels further right. Past the switch point the color reads
  // the upper half of the palette.
  function automatic bit [4:0] pick_slot(input int unsigned x, input bit [3:0] c);
    int unsigned switch_at;
    switch_at = 10 * int'(c);
    if (c[0]) switch_at = switch_at - 5;
    else      switch_at = switch_at + 1;
    if (c > 4'd7) switch_at = switch_at + 12;
    return (x >= switch_at + 75) ? {1'b1, c} : {1'b0, c};
  endfunction

  // Group positions past the end of the line clamp to the last group.
  function automatic int unsigned clamp_group(input bit [4:0] grp);
    return (grp > GROUPS_PER_LINE - 1) ? GROUPS_PER_LINE - 1 : int'(grp);
  endfunction

  // Applies one accepted item: a write updates the palette copy, a group
  // appends its sixteen pixels to the expectation queue.
  task automatic absorb_item();
    int unsigned g;
    bit [4:0]    slot;
    bit [11:0]   w0;
    bit [11:0]   w1;
    rgb_pixel_t  px;
    if (kind == KIND_PALETTE) begin
      if (palette_select) pal_second[palette_index] = color_word[11:0];
      else                pal_first[palette_index]  = color_word[11:0];
    end else begin
      g = clamp_group(group_index);
      for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
        slot = pick_slot(g * PIXELS_PER_GROUP + i,
                         pixel_color(plane_a, plane_b, plane_c, plane_d, i));
        w0 = pal_first[slot];
        w1 = pal_second[slot];
        px.r    = mix_channel(w0[11:8], w1[11:8]);
        px.g    = mix_channel(w0[7:4],  w1[7:4]);
        px.b    = mix_channel(w0[3:0],  w1[3:0]);
        px.last = (i == PIXELS_PER_GROUP - 1);
        pixel_expect.push_back(px);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------

  // The plane and group fields of a write are ignored by the block, so they
  // carry random values to prove it.
  task automatic queue_write(input bit sel, input bit [4:0] idx, input bit [15:0] word);
    planar_item_t it;
    it.hold   = hold_next;
    hold_next = 1'b0;
    it.kind   = KIND_PALETTE;
    it.sel    = sel;
    it.idx    = idx;
    it.word   = word;
    it.grp    = 5'($urandom_range(0, 31));
    it.pa     = 16'($urandom_range(0, 65535));
    it.pb     = 16'($urandom_range(0, 65535));
    it.pc     = 16'($urandom_range(0, 65535));
    it.pd     = 16'($urandom_range(0, 65535));
    pending.push_back(it);
    if (sel) filled_second[idx] = 1'b1;
    else     filled_first[idx]  = 1'b1;
  endtask

  // Queues a plane group, preceded by writes for any entry it would read that
  // has no value yet in either palette. The palette fields are random noise.
  task automatic queue_group(input bit [4:0] grp, input bit [15:0] pa, input bit [15:0] pb,
                             input bit [15:0] pc, input bit [15:0] pd);
    planar_item_t it;
    int unsigned  g;
    bit [4:0]     slot;
    g = clamp_group(grp);
    for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
      slot = pick_slot(g * PIXELS_PER_GROUP + i, pixel_color(pa, pb, pc, pd, i));
      if (!filled_first[slot])  queue_write(1'b0, slot, 16'($urandom_range(0, 65535)));
      if (!filled_second[slot]) queue_write(1'b1, slot, 16'($urandom_range(0, 65535)));
    end
    it.hold   = hold_next;
    hold_next = 1'b0;
    it.kind   = KIND_GROUP;
    it.sel    = 1'($urandom_range(0, 1));
    it.idx    = 5'($urandom_range(0, 31));
    it.word   = 16'($urandom_range(0, 65535));
    it.grp    = grp;
    it.pa     = pa;
    it.pb     = pb;
    it.pc     = pc;
    it.pd     = pd;
    pending.push_back(it);
  endtask

  // Random gaps on both sides, except inside the calm window.
  function automatic bit take_break();
    if (cyc >= CALM_FROM && cyc < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: inputs change on the falling edge only. A new item is presented
  // when the line is idle or when the previous one was transferred, which is
  // the case when the monitor has counted as many transfers as were offered.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_items
    planar_item_t it;
    if (!rst) begin
      if (!item_valid || item_xfers == item_offers) begin
        if (pending.size() != 0 && !(pending[0].hold && pixel_expect.size() != 0) &&
            !take_break()) begin
          it = pending.pop_front();
          kind           <= it.kind;
          palette_select <= it.sel;
          palette_index  <= it.idx;
          color_word     <= it.word;
          group_index    <= it.grp;
          plane_a        <= it.pa;
          plane_b        <= it.pb;
          plane_c        <= it.pc;
          plane_d        <= it.pd;
          item_valid     <= 1'b1;
          item_offers++;
        end else begin
          item_valid <= 1'b0;
        end
      end
      pixel_ready <= !take_break();
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: both channels are sampled on the rising edge. Pixel transfers are
  // checked against the oldest prediction; input transfers feed the predictor.
  // The quiet counter is the watchdog: it restarts on any transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    rgb_pixel_t want;
    if (!rst) begin
      cyc++;
      if (pixel_valid && pixel_ready) begin
        if (pixel_expect.size() == 0) begin
          $error("pixel transfer with no pixel predicted: r=%0d g=%0d b=%0d last=%0d",
                 red, green, blue, last_pixel);
          errors++;
        end else begin
          want = pixel_expect.pop_front();
          if (red !== want.r) begin
            $error("red: expected %0d, got %0d", want.r, red);
            errors++;
          end
          if (green !== want.g) begin
            $error("green: expected %0d, got %0d", want.g, green);
            errors++;
          end
          if (blue !== want.b) begin
            $error("blue: expected %0d, got %0d", want.b, blue);
            errors++;
          end
          if (last_pixel !== want.last) begin
            $error("last_pixel: expected %0d, got %0d", want.last, last_pixel);
            errors++;
          end
        end
      end
      if (item_valid && item_ready) begin
        absorb_item();
        item_xfers++;
      end
      if ((pixel_valid && pixel_ready) || (item_valid && item_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_test
    bit [4:0]  grp;
    bit [3:0]  c;
    bit [15:0] pa;
    bit [15:0] pb;
    bit [15:0] pc;
    bit [15:0] pd;

    // Directed part. Extreme palette words, some with the unused top nibble set,
    // at both ends and at entry 16 of both palettes.
    queue_write(1'b0, 5'd0,  16'h0000);
    queue_write(1'b1, 5'd0,  16'hFFFF);
    queue_write(1'b0, 5'd31, 16'hFFFF);
    queue_write(1'b1, 5'd31, 16'h0000);
    queue_write(1'b0, 5'd16, 16'hF0F0);
    queue_write(1'b1, 5'd16, 16'h0F0F);
    // Color zero at the left edge, color fifteen at the right edge.
    queue_group(5'd0,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_group(5'd19, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // A group position past the end of the line clamps to the last group.
    queue_group(5'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // Color zero changes entry inside group four, exactly at its switch pixel.
    queue_group(5'd4,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
    // Color one sits just below and just past its switch point.
    queue_group(5'd4,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    queue_group(5'd5,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    // Every color in one group, once in the lower and once in the upper half.
    queue_group(5'd0,  16'h5555, 16'h3333, 16'h0F0F, 16'h00FF);
    queue_group(5'd19, 16'h5555, 16'h3333, 16'h0F0F, 16'h00FF);

    // Random part. The first item and one in the middle wait for an empty
    // pixel queue before they are offered.
    hold_next = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) hold_next = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        queue_write(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                    16'($urandom_range(0, 65535)));
      end else begin
        grp = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(20, 31))
                                          : 5'($urandom_range(0, 19));
        if ($urandom_range(0, 3) == 0) begin
          // A solid run of one color makes the switch pixel easy to spot.
          c  = 4'($urandom_range(0, 15));
          pa = {16{c[0]}};
          pb = {16{c[1]}};
          pc = {16{c[2]}};
          pd = {16{c[3]}};
        end else begin
          pa = 16'($urandom_range(0, 65535));
          pb = 16'($urandom_range(0, 65535));
          pc = 16'($urandom_range(0, 65535));
          pd = 16'($urandom_range(0, 65535));
        end
        queue_group(grp, pa, pb, pc, pd);
      end
    end
    total_items = pending.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Run until every item is in and every predicted pixel came out, or until
    // the watchdog fires. Then give the block time to show any stray pixel.
    while (!(item_xfers == total_items && pixel_expect.size() == 0) &&
           quiet_cycles < WATCHDOG_LIMIT)
      @(negedge clk);
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no transfer for %0d cycles, %0d of %0d items in, %0d pixels outstanding",
             quiet_cycles, item_xfers, total_items, pixel_expect.size());
      errors++;
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
    end

    if (errors == 0) begin
      $display("raster_palette_planar_to_rgb_unit verification clean");
    end else begin
      $display("raster_palette_planar_to_rgb_unit verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/rpp_pkg.sv
sv/rpp_front.sv
sv/rpp_queue.sv
sv/rpp_back.sv
sv/raster_palette_planar_to_rgb_unit.sv
bench/tb_raster_palette_planar_to_rgb_unit.sv
